### hdl/mepid_pkg.sv
// shared types and constants of the expert pid speed controller
// used by the register block, controller, datapath and top level
`default_nettype none

package mepid_pkg;

    // configuration register indexes (byte address is 4 times the index)
    localparam logic [2:0] REG_PROP  = 3'd0;
    localparam logic [2:0] REG_DERIV = 3'd1;
    localparam logic [2:0] REG_INTEG = 3'd2;
    localparam logic [2:0] REG_LIMIT = 3'd3;
    localparam logic [2:0] REG_DMAX  = 3'd4;
    localparam logic [2:0] REG_DMIN  = 3'd5;

    // register reset values
    localparam logic signed [15:0] PROP_RST  = 16'sd0;
    localparam logic signed [15:0] DERIV_RST = 16'sd0;
    localparam logic [15:0]        INTEG_RST = 16'd19779;
    localparam logic [14:0]        LIMIT_RST = 15'd1000;
    localparam logic signed [15:0] DMAX_RST  = 16'sd32767;
    localparam logic signed [15:0] DMIN_RST  = -16'sd32768;

    // error clamp and expert rule threshold
    localparam logic signed [16:0] ERR_HI  = 17'sd64;
    localparam logic signed [16:0] ERR_LO  = -17'sd64;
    localparam logic [7:0]         MID_ERR = 8'd3;

    // datapath widths
    localparam int ACC_W = 37;  // q.12 sum before the boost gain
    localparam int Q_W   = 51;  // q.24 value after the boost gain
    localparam int RES_W = Q_W - 24;

    typedef struct packed {
        logic signed [15:0] prop_gain;
        logic signed [15:0] deriv_gain;
        logic [15:0]        integ_gain_q12;
        logic [14:0]        integ_limit;
        logic signed [15:0] drive_max;
        logic signed [15:0] drive_min;
    } cfg_t;

    typedef struct packed {
        logic accept;     // latch a new item and update the error history
        logic mul_prop;   // acc = kp * e
        logic mul_deriv;  // acc += kd * d1
        logic mul_integ;  // acc = acc * 4096 + sum * ki
        logic scale;      // apply the boost gain, q.24
        logic round;      // divide by 2^24 toward zero
        logic load;       // clamp and load the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;   // output register can take a new item
    } dp_status_t;

endpackage

`default_nettype wire

### hdl/motor_expert_pid.sv
// top level of the expert pid speed controller
// joins mepid_regs, mepid_ctrl and mepid_dp; types from mepid_pkg
//
// usage:
//   one item on the s_ stream is one control tick: setpoint and measured
//   speed. the block answers each tick with exactly one item on the m_
//   stream: the clamped drive value and a flag that the expert rule boosted
//   the output by 4383/4096.
//   gains, integral limit and drive bounds sit in an apb-style register
//   block (index i at byte address 4*i); write them only while idle.
// timing:
//   one item is in work at a time. a tick runs from acceptance through the
//   three passes through the one shared 17x17 multiplier plus the scale,
//   round and clamp steps; the result then sits in the output register, and
//   the block accepts the next tick once that result is loaded.
//   the output register lets the next tick be accepted while a result waits;
//   if the receiver stalls, the block finishes the next tick and then holds
//   it, and s_tready stays low until the waiting result is taken.
// reset:
//   aresetn (synchronous, active low) clears the integral and the error
//   history, empties the output register and restores register defaults.
`default_nettype none

module motor_expert_pid
    import mepid_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] setpoint, [31:16] measured
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] drive
    output logic [0:0]       m_tuser,   // [0] boosted
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t               cfg;
    ctrl_cmd_t          cmd;
    dp_status_t         status;
    logic signed [15:0] drive;
    logic               boosted;

    mepid_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: accepts in idle, then steps the datapath
    mepid_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath reads the stream payload only on the accept command
    mepid_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .status   (status),
        .setpoint (s_tdata[15:0]),
        .measured (s_tdata[31:16]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .drive    (drive),
        .boosted  (boosted)
    );

    assign m_tdata    = drive;
    assign m_tuser[0] = boosted;

endmodule

`default_nettype wire

### hdl/mepid_regs.sv
// apb-style configuration registers of the expert pid controller
// depends on mepid_pkg for the register indexes and cfg_t
`default_nettype none

module mepid_regs
    import mepid_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain      <= PROP_RST;
            cfg_reg.deriv_gain     <= DERIV_RST;
            cfg_reg.integ_gain_q12 <= INTEG_RST;
            cfg_reg.integ_limit    <= LIMIT_RST;
            cfg_reg.drive_max      <= DMAX_RST;
            cfg_reg.drive_min      <= DMIN_RST;
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_PROP:  cfg_reg.prop_gain      <= pwdata[15:0];
                REG_DERIV: cfg_reg.deriv_gain     <= pwdata[15:0];
                REG_INTEG: cfg_reg.integ_gain_q12 <= pwdata[15:0];
                REG_LIMIT: cfg_reg.integ_limit    <= pwdata[14:0];
                REG_DMAX:  cfg_reg.drive_max      <= pwdata[15:0];
                REG_DMIN:  cfg_reg.drive_min      <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_PROP:  prdata = {16'd0, cfg_reg.prop_gain};
            REG_DERIV: prdata = {16'd0, cfg_reg.deriv_gain};
            REG_INTEG: prdata = {16'd0, cfg_reg.integ_gain_q12};
            REG_LIMIT: prdata = {17'd0, cfg_reg.integ_limit};
            REG_DMAX:  prdata = {16'd0, cfg_reg.drive_max};
            REG_DMIN:  prdata = {16'd0, cfg_reg.drive_min};
            default:   prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

### hdl/mepid_ctrl.sv
// sequencing state machine of the expert pid controller
// depends on mepid_pkg for the command and status structs
`default_nettype none

module mepid_ctrl
    import mepid_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire dp_status_t  status,
    output ctrl_cmd_t        cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PROP  = 3'd1;
    localparam logic [2:0] ST_DERIV = 3'd2;
    localparam logic [2:0] ST_INTEG = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;
    localparam logic [2:0] ST_ROUND = 3'd5;
    localparam logic [2:0] ST_LOAD  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_PROP;
                end
            end
            ST_PROP: begin
                cmd.mul_prop = 1'b1;
                state_next   = ST_DERIV;
            end
            ST_DERIV: begin
                cmd.mul_deriv = 1'b1;
                state_next    = ST_INTEG;
            end
            ST_INTEG: begin
                cmd.mul_integ = 1'b1;
                state_next    = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                // hold here while the previous item still waits at the output
                cmd.load = status.out_free;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### hdl/mepid_dp.sv
// datapath of the expert pid controller: error history, shared multiplier,
// boost scaling, rounding, drive clamp and output register; uses mepid_pkg
`default_nettype none

module mepid_dp
    import mepid_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cfg_t               cfg,
    input  wire ctrl_cmd_t          cmd,
    output dp_status_t              status,
    input  wire logic signed [15:0] setpoint,
    input  wire logic signed [15:0] measured,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic signed [15:0]      drive,
    output logic                    boosted
);

    // error history state
    logic signed [15:0] error_sum_reg;
    logic signed [7:0]  last_error_reg;
    logic signed [7:0]  prior_error_reg;

    // per-item working registers
    logic signed [7:0]       e_reg;
    logic signed [8:0]       d1_reg;
    logic                    boost_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [Q_W-1:0]   q_reg;
    logic signed [Q_W-1:0]   q_next;
    logic signed [RES_W-1:0] res_reg;
    logic signed [RES_W-1:0] res_next;
    logic                    out_valid_reg;
    logic signed [15:0]      drive_reg;
    logic signed [15:0]      drive_next;
    logic                    boosted_reg;

    // accept-time logic
    logic signed [16:0] diff;
    logic signed [7:0]  e_new;
    logic [7:0]         abs_e;
    logic signed [16:0] sum_raw;
    logic signed [16:0] lim_pos;
    logic signed [16:0] lim_neg;
    logic signed [15:0] sum_new;
    logic signed [8:0]  d1_new;
    logic signed [8:0]  d2_new;
    logic               e_nz, d1_nz, d2_nz, last_nz;
    logic               grow, rev, boost_new;

    always_comb begin
        diff = {setpoint[15], setpoint} - {measured[15], measured};
        if (diff > ERR_HI) begin
            e_new = ERR_HI[7:0];
        end else if (diff < ERR_LO) begin
            e_new = ERR_LO[7:0];
        end else begin
            e_new = diff[7:0];
        end
        abs_e = e_new[7] ? 8'(-e_new) : 8'(e_new);

        lim_pos = $signed({2'b00, cfg.integ_limit});
        lim_neg = -lim_pos;
        sum_raw = {error_sum_reg[15], error_sum_reg} + {{9{e_new[7]}}, e_new};
        if (sum_raw > lim_pos) begin
            sum_new = lim_pos[15:0];
        end else if (sum_raw < lim_neg) begin
            sum_new = lim_neg[15:0];
        end else begin
            sum_new = sum_raw[15:0];
        end

        d1_new = {e_new[7], e_new} - {last_error_reg[7], last_error_reg};
        d2_new = {last_error_reg[7], last_error_reg} - {prior_error_reg[7], prior_error_reg};

        // sign tests stand in for the products of the rule
        e_nz    = (e_new != 8'sd0);
        d1_nz   = (d1_new != 9'sd0);
        d2_nz   = (d2_new != 9'sd0);
        last_nz = (last_error_reg != 8'sd0);
        grow = (e_nz && d1_nz && (e_new[7] == d1_new[8])
                && last_nz && d2_nz && (last_error_reg[7] == d2_new[8]))
               || !d1_nz;
        rev  = e_nz && d1_nz && (e_new[7] != d1_new[8])
               && d2_nz && (d1_new[8] != d2_new[8]);
        if (grow) begin
            boost_new = (abs_e >= MID_ERR);
        end else if (rev) begin
            boost_new = (abs_e > MID_ERR);
        end else begin
            boost_new = 1'b0;
        end
    end

    // shared 17 x 17 signed multiplier
    logic signed [16:0]      mul_a;
    logic signed [16:0]      mul_b;
    logic signed [33:0]      prod;
    logic signed [ACC_W-1:0] prod_ext;

    always_comb begin
        if (cmd.mul_integ) begin
            mul_a = {error_sum_reg[15], error_sum_reg};
            mul_b = $signed({1'b0, cfg.integ_gain_q12});
        end else if (cmd.mul_deriv) begin
            mul_a = {cfg.deriv_gain[15], cfg.deriv_gain};
            mul_b = {{8{d1_reg[8]}}, d1_reg};
        end else begin
            mul_a = {cfg.prop_gain[15], cfg.prop_gain};
            mul_b = {{9{e_reg[7]}}, e_reg};
        end
        prod     = mul_a * mul_b;
        prod_ext = {{(ACC_W - 34){prod[33]}}, prod};
    end

    logic signed [Q_W-1:0] acc_w;
    logic signed [Q_W-1:0] boost_part;
    logic signed [Q_W-1:0] q_biased;
    logic signed [RES_W-1:0] max_w;
    logic signed [RES_W-1:0] min_w;
    logic signed [RES_W-1:0] hi_clamped;

    always_comb begin
        acc_next = acc_reg;
        if (cmd.mul_prop) begin
            acc_next = prod_ext;
        end else if (cmd.mul_deriv) begin
            acc_next = acc_reg + prod_ext;
        end else if (cmd.mul_integ) begin
            acc_next = (acc_reg <<< 12) + prod_ext;
        end

        // boost gain 4383 = 4096 + 256 + 32 - 1
        acc_w      = {{(Q_W - ACC_W){acc_reg[ACC_W-1]}}, acc_reg};
        boost_part = boost_reg ? ((acc_w <<< 8) + (acc_w <<< 5) - acc_w) : '0;
        q_next     = cmd.scale ? ((acc_w <<< 12) + boost_part) : q_reg;

        // truncate toward zero on the divide by 2^24
        q_biased = q_reg + (q_reg[Q_W-1] ? Q_W'(24'hFF_FFFF) : Q_W'(0));
        res_next = cmd.round ? q_biased[Q_W-1:24] : res_reg;

        // upper bound first, lower bound second
        max_w      = {{(RES_W - 16){cfg.drive_max[15]}}, cfg.drive_max};
        min_w      = {{(RES_W - 16){cfg.drive_min[15]}}, cfg.drive_min};
        hi_clamped = (res_reg > max_w) ? max_w : res_reg;
        drive_next = (hi_clamped < min_w) ? cfg.drive_min : hi_clamped[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg   <= 16'sd0;
            last_error_reg  <= 8'sd0;
            prior_error_reg <= 8'sd0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cmd.accept) begin
                error_sum_reg   <= sum_new;
                last_error_reg  <= e_new;
                prior_error_reg <= last_error_reg;
            end
            if (cmd.load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            e_reg     <= e_new;
            d1_reg    <= d1_new;
            boost_reg <= boost_new;
        end
        acc_reg <= acc_next;
        q_reg   <= q_next;
        res_reg <= res_next;
        if (cmd.load) begin
            drive_reg   <= drive_next;
            boosted_reg <= boost_reg;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign drive           = drive_reg;
    assign boosted         = boosted_reg;

endmodule

`default_nettype wire
